/* hw/rtl/crom_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the cascaded range offset remap block.
// No dependencies.
package crom_pkg;

    localparam int NUM_STAGES        = 7;
    localparam int ENTRIES_PER_STAGE = 32;
    localparam int TOTAL_ENTRIES     = NUM_STAGES * ENTRIES_PER_STAGE;
    localparam int ENTRY_W           = (TOTAL_ENTRIES > 1) ? $clog2(TOTAL_ENTRIES) : 1;
    localparam int SLOT_W            = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef struct packed {
        logic [31:0] low;
        logic [32:0] high;
        logic [31:0] dest;
    } entry_t;

    typedef struct packed {
        action_t              kind;
        logic [ENTRY_W-1:0]   idx;
        entry_t               entry;
        logic [31:0]          key;
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_CHECK,
        S_EMIT
    } back_state_t;

endpackage

/* hw/rtl/crom_front.sv */
`timescale 1ns / 1ps
// Front end: classify incoming transactions and build queue commands.
// Depends on crom_pkg.
module crom_front
    import crom_pkg::*;
(
    input  logic [1:0]  action,
    input  logic [2:0]  stage_select,
    input  logic [4:0]  entry_slot,
    input  logic [31:0] source_begin,
    input  logic [31:0] span_length,
    input  logic [31:0] dest_begin,
    input  logic [31:0] lookup_key,
    output logic        keep,
    output cmd_t        cmd
);

    logic in_range;

    always_comb
    begin
        in_range = (int'(stage_select) < NUM_STAGES) && (int'(entry_slot) < ENTRIES_PER_STAGE);
        cmd.idx  = ENTRY_W'(int'(stage_select) * ENTRIES_PER_STAGE + int'(entry_slot));
        cmd.entry.low  = source_begin;
        cmd.entry.high = {1'b0, source_begin} + {1'b0, span_length};
        cmd.entry.dest = dest_begin;
        cmd.key  = lookup_key;
        cmd.kind = ACT_NONE;
        keep     = 1'b0;
        unique case (action)
            ACT_LOAD:
            begin
                cmd.kind = ACT_LOAD;
                keep     = in_range;
            end
            ACT_LOOKUP:
            begin
                cmd.kind = ACT_LOOKUP;
                keep     = 1'b1;
            end
            ACT_CLEAR:
            begin
                cmd.kind = ACT_CLEAR;
                keep     = 1'b1;
            end
            default:
            begin
                cmd.kind = ACT_NONE;
                keep     = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/crom_queue.sv */
`timescale 1ns / 1ps
// Short command queue between front and back ends.
// Depends on crom_pkg.
module crom_queue
    import crom_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic nonempty
);

    cmd_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign head     = slots_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !nonempty |-> !pop)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

/* hw/rtl/crom_back.sv */
`timescale 1ns / 1ps
// Back end: entry table memory, valid bits and the slot-by-slot lookup scan.
// Depends on crom_pkg.
module crom_back
    import crom_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_avail,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] final_value
);

    entry_t                   mem [TOTAL_ENTRIES];
    back_state_t              state_reg, state_next;
    logic [ENTRY_W-1:0]       idx_reg, idx_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic [31:0]              key_reg, key_next;
    logic [31:0]              res_reg, res_next;
    logic                     hit_reg, hit_next;
    logic [TOTAL_ENTRIES-1:0] valid_bits_reg;
    entry_t                   rd_entry_reg;
    logic                     rd_valid_reg;
    logic                     match;
    logic [31:0]              mapped;

    assign cmd_pop     = (state_reg == S_IDLE) && cmd_avail;
    assign out_valid   = (state_reg == S_EMIT);
    assign final_value = key_reg;

    always_comb
    begin
        match  = rd_valid_reg && (key_reg >= rd_entry_reg.low)
                 && ({1'b0, key_reg} < rd_entry_reg.high);
        mapped = rd_entry_reg.dest + (key_reg - rd_entry_reg.low);
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        slot_next  = slot_reg;
        key_next   = key_reg;
        res_next   = res_reg;
        hit_next   = hit_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_pop && cmd.kind == ACT_LOOKUP)
                begin
                    key_next   = cmd.key;
                    idx_next   = '0;
                    slot_next  = '0;
                    hit_next   = 1'b0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (match && !hit_reg)
                begin
                    res_next = mapped;
                    hit_next = 1'b1;
                end
                if (slot_reg == SLOT_W'(ENTRIES_PER_STAGE - 1))
                begin
                    slot_next = '0;
                    hit_next  = 1'b0;
                    if (hit_reg)
                    begin
                        key_next = res_reg;
                    end
                    else if (match)
                    begin
                        key_next = mapped;
                    end
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
                if (idx_reg == ENTRY_W'(TOTAL_ENTRIES - 1))
                begin
                    idx_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_EMIT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            slot_reg  <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            slot_reg  <= slot_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_bits_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd_pop && cmd.kind == ACT_CLEAR)
            begin
                valid_bits_reg <= '0;
            end
            else if (cmd_pop && cmd.kind == ACT_LOAD)
            begin
                valid_bits_reg[cmd.idx] <= 1'b1;
            end
            if (state_reg == S_FETCH)
            begin
                rd_valid_reg <= valid_bits_reg[idx_reg];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.kind == ACT_LOAD)
        begin
            mem[cmd.idx] <= cmd.entry;
        end
        if (state_reg == S_FETCH)
        begin
            rd_entry_reg <= mem[idx_reg];
        end
    end

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd.kind == ACT_CLEAR) |=> (valid_bits_reg == '0))
        else $error("clear left valid entries");
    a_load_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd.kind == ACT_LOAD) |=> valid_bits_reg[$past(cmd.idx)])
        else $error("load did not mark entry valid");
    a_emit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (idx_reg == '0 && slot_reg == '0 && !hit_reg))
        else $error("result shown before scan finished");

endmodule

/* hw/rtl/cascaded_range_offset_remap.sv */
`timescale 1ns / 1ps
// Load and clear take effect at the edge that takes them from the queue. The back end
// takes a command only while idle; a lookup reads each entry in S_FETCH, tests it in
// S_CHECK, stage by stage, and holds its result in S_EMIT until out_stall is low.
// Single table memory read port; load and clear sustain one per cycle while idle.
// Reset: asynchronous; clears all valid bits at once, no sweep needed.
// Depends on crom_pkg, crom_front, crom_queue, crom_back.
module cascaded_range_offset_remap
    import crom_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [2:0]  stage_select,
    input  logic [4:0]  entry_slot,
    input  logic [31:0] source_begin,
    input  logic [31:0] span_length,
    input  logic [31:0] dest_begin,
    input  logic [31:0] lookup_key,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] final_value
);

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic keep;
    logic full;
    logic nonempty;
    logic pop;
    logic push;

    assign in_stall = full;
    assign push     = in_valid && !full && keep;

    crom_front u_front (
        .action       (action),
        .stage_select (stage_select),
        .entry_slot   (entry_slot),
        .source_begin (source_begin),
        .span_length  (span_length),
        .dest_begin   (dest_begin),
        .lookup_key   (lookup_key),
        .keep         (keep),
        .cmd          (front_cmd)
    );

    crom_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (head_cmd),
        .full     (full),
        .nonempty (nonempty)
    );

    crom_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_avail   (nonempty),
        .cmd         (head_cmd),
        .cmd_pop     (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .final_value (final_value)
    );

endmodule
